>>> rtl/c2p_pkg.sv
`timescale 1ns / 1ps

package c2p_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int ITERATIONS  = 24;
    localparam int GUARD       = 8;

    // datapath widths: CORDIC gain and the quarter turn need headroom above the guard bits
    localparam int XW     = COORD_WIDTH + GUARD + 3;
    localparam int AW     = 32;                  // accumulator units: 2^31 is pi
    localparam int ZW     = AW + 2;
    localparam int ANG_SH = AW - COORD_WIDTH;
    localparam int MW     = XW - GUARD;          // rounded magnitude before gain correction
    localparam int INVK_W    = 30;
    localparam int INVK_FRAC = 30;
    localparam int PW     = MW + INVK_W;
    localparam int MAG2W  = PW + 1 - INVK_FRAC;

    // beat passes the pre-rotation register, the iteration registers and the post stages
    localparam int LATENCY = ITERATIONS + 4;

    localparam logic [INVK_W-1:0] INVK_Q30  = INVK_W'(652032874);
    localparam logic [ZW-1:0]     Z_QUARTER = ZW'(1) << (AW - 2);
    localparam logic [ZW-1:0]     Z_ROUND   = (ANG_SH > 0) ? (ZW'(1) << (ANG_SH - 1)) : '0;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } t_c2p_in;

    typedef struct packed {
        logic        [COORD_WIDTH-1:0] magnitude;
        logic signed [COORD_WIDTH-1:0] angle;
    } t_c2p_out;

    typedef struct packed {
        logic              zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_c2p_stage;

    // atan(2^-i) with 2^31 standing for pi
    function automatic logic [ZW-1:0] step_angle(input logic [4:0] idx);
        logic [ZW-1:0] a;
        case (idx)
            5'd0:  a = ZW'(536870912);
            5'd1:  a = ZW'(316933406);
            5'd2:  a = ZW'(167458907);
            5'd3:  a = ZW'(85004756);
            5'd4:  a = ZW'(42667331);
            5'd5:  a = ZW'(21354465);
            5'd6:  a = ZW'(10679838);
            5'd7:  a = ZW'(5340245);
            5'd8:  a = ZW'(2670163);
            5'd9:  a = ZW'(1335087);
            5'd10: a = ZW'(667544);
            5'd11: a = ZW'(333772);
            5'd12: a = ZW'(166886);
            5'd13: a = ZW'(83443);
            5'd14: a = ZW'(41722);
            5'd15: a = ZW'(20861);
            5'd16: a = ZW'(10430);
            5'd17: a = ZW'(5215);
            5'd18: a = ZW'(2608);
            5'd19: a = ZW'(1304);
            5'd20: a = ZW'(652);
            5'd21: a = ZW'(326);
            5'd22: a = ZW'(163);
            5'd23: a = ZW'(81);
            5'd24: a = ZW'(41);
            5'd25: a = ZW'(20);
            5'd26: a = ZW'(10);
            5'd27: a = ZW'(5);
            5'd28: a = ZW'(3);
            5'd29: a = ZW'(1);
            5'd30: a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/c2p_prerot.sv
`timescale 1ns / 1ps

module c2p_prerot (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  c2p_pkg::t_c2p_in    i_vec,
    output logic                o_valid,
    output c2p_pkg::t_c2p_stage o_stg
);
    import c2p_pkg::*;

    logic                 r_valid;
    t_c2p_stage           r_stg;
    t_c2p_stage           n_stg;
    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;
    logic signed [XW-1:0] rx;
    logic signed [XW-1:0] ry;

    assign x_ext = {{(XW-COORD_WIDTH){i_vec.x_coord[COORD_WIDTH-1]}}, i_vec.x_coord};
    assign y_ext = {{(XW-COORD_WIDTH){i_vec.y_coord[COORD_WIDTH-1]}}, i_vec.y_coord};

    // left half plane: quarter turn so x >= 0, angle accumulator preloaded
    always_comb begin
        rx      = x_ext;
        ry      = y_ext;
        n_stg.z = '0;
        if (x_ext < 0) begin
            if (y_ext >= 0) begin
                rx      = y_ext;
                ry      = -x_ext;
                n_stg.z = Z_QUARTER;
            end else begin
                rx      = -y_ext;
                ry      = x_ext;
                n_stg.z = -Z_QUARTER;
            end
        end
        n_stg.x    = rx <<< GUARD;
        n_stg.y    = ry <<< GUARD;
        n_stg.zero = (x_ext == '0) && (y_ext == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stg <= n_stg;
    end

    assign o_valid = r_valid;
    assign o_stg   = r_stg;

`ifndef ASSERT_OFF
    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_stg.zero |-> !r_stg.x[XW-1])
        else $error("pre-rotation left x negative");
`endif

endmodule

>>> rtl/c2p_core.sv
`timescale 1ns / 1ps

module c2p_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  c2p_pkg::t_c2p_stage i_stg,
    output logic                o_valid,
    output c2p_pkg::t_c2p_stage o_stg
);
    import c2p_pkg::*;

    logic       r_valid [ITERATIONS];
    t_c2p_stage r_stg   [ITERATIONS];

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        t_c2p_stage           src;
        logic                 src_valid;
        t_c2p_stage           n_stg;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        if (i == 0) begin : g_first
            assign src       = i_stg;
            assign src_valid = i_valid;
        end else begin : g_next
            assign src       = r_stg[i-1];
            assign src_valid = r_valid[i-1];
        end

        // one vectoring step; y of zero counts as non-negative
        always_comb begin
            xs         = src.x >>> i;
            ys         = src.y >>> i;
            n_stg.zero = src.zero;
            if (!src.y[XW-1]) begin
                n_stg.x = src.x + ys;
                n_stg.y = src.y - xs;
                n_stg.z = src.z + step_angle(5'(i));
            end else begin
                n_stg.x = src.x - ys;
                n_stg.y = src.y + xs;
                n_stg.z = src.z - step_angle(5'(i));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else begin
                r_valid[i] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_stg[i] <= n_stg;
        end
    end

    assign o_valid = r_valid[ITERATIONS-1];
    assign o_stg   = r_stg[ITERATIONS-1];

`ifndef ASSERT_OFF
    a_core_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[ITERATIONS-1] |-> $past(i_valid, ITERATIONS))
        else $error("beat left the iteration chain without entering it");
`endif

endmodule

>>> rtl/c2p_post.sv
`timescale 1ns / 1ps

module c2p_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  c2p_pkg::t_c2p_stage i_stg,
    output logic                o_valid,
    output c2p_pkg::t_c2p_out   o_polar
);
    import c2p_pkg::*;

    // stage A: round x to whole units, round angle to output units
    logic                   r_a_valid;
    logic [MW-1:0]          r_a_mag;
    logic [COORD_WIDTH-1:0] r_a_ang;
    logic [MW-1:0]          n_a_mag;
    logic [COORD_WIDTH-1:0] n_a_ang;
    logic [XW-1:0]          x_clamp;
    logic [XW-1:0]          x_rnd;
    logic [ZW-1:0]          z_rnd;

    // stage B: gain correction product
    logic                   r_b_valid;
    logic [PW-1:0]          r_b_prod;
    logic [COORD_WIDTH-1:0] r_b_ang;

    // stage C: round, saturate, output register
    logic                   r_c_valid;
    t_c2p_out               r_c_out;
    t_c2p_out               n_c_out;
    logic [PW:0]            prod_rnd;
    logic [MAG2W-1:0]       mag2;

    always_comb begin
        x_clamp = i_stg.x[XW-1] ? '0 : i_stg.x;
        x_rnd   = x_clamp + (XW'(1) << (GUARD - 1));
        z_rnd   = i_stg.z + Z_ROUND;
        n_a_mag = x_rnd[XW-1:GUARD];
        n_a_ang = z_rnd[ANG_SH +: COORD_WIDTH];
        if (i_stg.zero) begin
            n_a_mag = '0;
            n_a_ang = '0;
        end
    end

    always_comb begin
        prod_rnd = {1'b0, r_b_prod} + ((PW+1)'(1) << (INVK_FRAC - 1));
        mag2     = prod_rnd[PW:INVK_FRAC];
        n_c_out.angle     = r_b_ang;
        n_c_out.magnitude = mag2[COORD_WIDTH-1:0];
        if (|mag2[MAG2W-1:COORD_WIDTH]) begin
            n_c_out.magnitude = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_mag  <= n_a_mag;
        r_a_ang  <= n_a_ang;
        r_b_prod <= PW'(r_a_mag) * PW'(INVK_Q30);
        r_b_ang  <= r_a_ang;
        r_c_out  <= n_c_out;
    end

    assign o_valid = r_c_valid;
    assign o_polar = r_c_out;

endmodule

>>> rtl/cartesian_to_polar.sv
`timescale 1ns / 1ps

// Cartesian to polar converter, pipelined CORDIC in vectoring mode.
// Input: drive i_vec (signed x_coord, y_coord) and pulse start; a beat is
// taken at every rising edge with start high and busy low. busy is held low,
// so a new vector may enter on every cycle.
// Output: o_valid is high for one cycle with o_polar holding the unsigned
// magnitude (gain corrected, saturated to all ones) and the signed angle,
// where 2^(COORD_WIDTH-1) is pi. A zero vector gives zero for both.
// Pipeline: a vector passes one pre-rotation stage, one register per CORDIC
// iteration, then rounding, gain multiply and saturation stages.
// Throughput: one vector per cycle, set by the one-step-per-stage chain.
// Results appear in input order; the receiver has no way to hold them off,
// so it must take each beat in the cycle it is shown.
// Reset (i_rst_n low, synchronous) clears every stage valid bit, so beats in
// flight are dropped and o_valid stays low until a new beat has passed through.
module cartesian_to_polar (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  c2p_pkg::t_c2p_in  i_vec,
    output logic              o_valid,
    output c2p_pkg::t_c2p_out o_polar
);
    import c2p_pkg::*;

    logic       accept;
    logic       pre_valid;
    t_c2p_stage pre_stg;
    logic       core_valid;
    t_c2p_stage core_stg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    c2p_prerot u_prerot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_vec   (i_vec),
        .o_valid (pre_valid),
        .o_stg   (pre_stg)
    );

    c2p_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pre_valid),
        .i_stg   (pre_stg),
        .o_valid (core_valid),
        .o_stg   (core_stg)
    );

    c2p_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .i_stg   (core_stg),
        .o_valid (o_valid),
        .o_polar (o_polar)
    );

`ifndef ASSERT_OFF
    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching input beat");

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past((i_vec.x_coord == '0) && (i_vec.y_coord == '0), LATENCY)
        |-> (o_polar.magnitude == '0) && (o_polar.angle == '0))
        else $error("zero vector gave a nonzero result");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import c2p_pkg::*;

    localparam int  CMAX      = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int  CMIN      = -(2 ** (COORD_WIDTH - 1));
    localparam int  QUIET_MAX = 2000;
    localparam int  N_RANDOM  = 1530;

    localparam longint          FRAC_BITS    = 8;
    localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;
    localparam longint          QUARTER_TURN = 64'sd1073741824;   // pi/2, 2^31 = pi

    // Predicts polar beats from accepted vectors and checks them in order.
    class polar_scoreboard;
        t_c2p_out expected_polar[$];
        int       n_checked;
        int       n_errors;
        // atan(2^-i) with 2^31 standing for pi
        longint atan_q31 [32] = '{
            536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245,
            2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861,
            10430, 5215, 2608, 1304,
            652, 326, 163, 81,
            41, 20, 10, 5,
            3, 1, 1, 0
        };

        function new();
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function t_c2p_out polar_of(t_c2p_in v);
            longint          xa;
            longint          ya;
            longint          za;
            longint          xs;
            longint          ys;
            longint          tmp;
            longint unsigned mag;
            t_c2p_out        r;
            xa = longint'(v.x_coord);
            ya = longint'(v.y_coord);
            za = 0;
            r  = '0;
            if (xa == 0 && ya == 0)
                return r;
            // fold left half-plane into the right one
            if (xa < 0) begin
                if (ya >= 0) begin
                    tmp = ya; ya = -xa; xa = tmp;
                    za  = QUARTER_TURN;
                end else begin
                    tmp = -ya; ya = xa; xa = tmp;
                    za  = -QUARTER_TURN;
                end
            end
            xa = xa * (64'sd1 <<< FRAC_BITS);
            ya = ya * (64'sd1 <<< FRAC_BITS);
            for (int i = 0; i < ITERATIONS; i++) begin
                xs = xa >>> i;
                ys = ya >>> i;
                if (ya >= 0) begin
                    xa = xa + ys;
                    ya = ya - xs;
                    za = za + atan_q31[i % 32];
                end else begin
                    xa = xa - ys;
                    ya = ya + xs;
                    za = za - atan_q31[i % 32];
                end
            end
            if (xa < 0)
                xa = 0;
            mag = (longint'(xa) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            mag = (mag * INV_GAIN_Q30 + (64'd1 << 29)) >> 30;
            if (mag > longint'((64'd1 << COORD_WIDTH) - 1))
                mag = (64'd1 << COORD_WIDTH) - 1;
            if (32 > COORD_WIDTH)
                za = (za + (64'sd1 <<< (32 - COORD_WIDTH - 1))) >>> (32 - COORD_WIDTH);
            r.magnitude = mag[COORD_WIDTH-1:0];
            r.angle     = za[COORD_WIDTH-1:0];
            return r;
        endfunction

        function void note_vector(t_c2p_in v);
            expected_polar.push_back(polar_of(v));
        endfunction

        function void check_polar(t_c2p_out got);
            t_c2p_out want;
            if (expected_polar.size() == 0) begin
                $display("%0t: unexpected beat mag=%0d ang=%0d", $time,
                         got.magnitude, got.angle);
                n_errors++;
                return;
            end
            want = expected_polar.pop_front();
            n_checked++;
            if (got.magnitude !== want.magnitude) begin
                $display("%0t: magnitude mismatch expected %0d actual %0d", $time,
                         want.magnitude, got.magnitude);
                n_errors++;
            end
            if (got.angle !== want.angle) begin
                $display("%0t: angle mismatch expected %0d actual %0d", $time,
                         want.angle, got.angle);
                n_errors++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_c2p_in  i_vec;
    logic     o_valid;
    t_c2p_out o_polar;

    polar_scoreboard sb;
    bit              gaps_on;
    int              n_sent;
    int              quiet;

    cartesian_to_polar i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_vec   (i_vec),
        .o_valid (o_valid),
        .o_polar (o_polar)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sample both sides at the rising edge, before the DUT's registers move
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_vector(i_vec);
                n_sent++;
            end
            if (o_valid)
                sb.check_polar(o_polar);
            if ((start && !busy) || o_valid)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("%0t: watchdog expired, %0d beats outstanding", $time,
                         sb.expected_polar.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic t_c2p_in vec_of(int x, int y);
        t_c2p_in v;
        v.x_coord = COORD_WIDTH'(x);
        v.y_coord = COORD_WIDTH'(y);
        return v;
    endfunction

    function automatic int rand_coord();
        int s;
        case ($urandom_range(4))
            0: s = int'($urandom_range(64)) - 32;
            1: s = $urandom_range(1) ? CMAX - int'($urandom_range(8))
                                     : CMIN + int'($urandom_range(8));
            2: s = 0;
            default: s = int'($urandom);
        endcase
        return s;
    endfunction

    function automatic t_c2p_in rand_vec();
        t_c2p_in v;
        if ($urandom_range(1)) begin
            v.x_coord = COORD_WIDTH'($urandom);
            v.y_coord = COORD_WIDTH'($urandom);
        end else begin
            v.x_coord = COORD_WIDTH'(rand_coord());
            v.y_coord = COORD_WIDTH'(rand_coord());
        end
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_vec(input t_c2p_in v);
        while (gaps_on && $urandom_range(99) < 30) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_vec <= v;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        sb      = new();
        gaps_on = 1'b1;
        n_sent  = 0;
        quiet   = 0;
        start   = 1'b0;
        i_vec   = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // axes, corners, zero vector and the pi wrap on the negative x axis
        send_vec(vec_of(0, 0));
        send_vec(vec_of(CMAX, 0));
        send_vec(vec_of(CMIN, 0));
        send_vec(vec_of(0, CMAX));
        send_vec(vec_of(0, CMIN));
        send_vec(vec_of(CMAX, CMAX));
        send_vec(vec_of(CMIN, CMIN));
        send_vec(vec_of(CMIN, CMAX));
        send_vec(vec_of(CMAX, CMIN));
        send_vec(vec_of(-1, 0));
        send_vec(vec_of(-5, 0));
        send_vec(vec_of(1, 0));
        send_vec(vec_of(0, 1));
        send_vec(vec_of(0, -1));
        send_vec(vec_of(-1, 1));
        send_vec(vec_of(1, -1));
        send_vec(vec_of(-1, -1));
        send_vec(vec_of(3, 4));
        send_vec(vec_of(-3, -4));
        send_vec(vec_of(CMIN, -1));
        send_vec(vec_of(CMIN, 1));
        send_vec(vec_of(0, 0));

        for (int k = 0; k < N_RANDOM; k++) begin
            gaps_on = !(k >= 500 && k < 800);   // back-to-back stretch
            send_vec(rand_vec());
        end
        start <= 1'b0;

        while (sb.expected_polar.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("covered %0d vectors (axes, corners, zero, random), %0d beats checked",
                 n_sent, sb.n_checked);
        $display("mismatches: %0d, left over: %0d", sb.n_errors, sb.expected_polar.size());
        if (sb.n_errors == 0 && sb.expected_polar.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
